// ===== rtl/prs_pkg.sv =====
// PRESENT-80 shared definitions: widths, round count, S-box and permutation.
// Used by prs_round and present80_block_encrypt; depends on nothing.
`default_nettype none

package prs_pkg;

  localparam int BLK_W  = 64;
  localparam int KEY_W  = 80;
  localparam int KLO_W  = 64;
  localparam int KHI_W  = 16;
  localparam int ROUNDS = 31;
  localparam int RND_W  = $clog2(ROUNDS + 1);

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] state;
    logic [KEY_W-1:0] key;
  } prs_stage_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hc;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hb;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'ha;
      4'h7: y = 4'hd;
      4'h8: y = 4'h3;
      4'h9: y = 4'he;
      4'ha: y = 4'hf;
      4'hb: y = 4'h8;
      4'hc: y = 4'h4;
      4'hd: y = 4'h7;
      4'he: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    for (int n = 0; n < BLK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to 16*(i mod 4) + i/4, i.e. 16*i mod 63 with bit 63 fixed
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    logic [5:0]       i6;
    for (int i = 0; i < BLK_W; i++) begin
      i6 = 6'(i);
      r[{i6[1:0], i6[5:2]}] = s[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/prs_round.sv =====
// One registered PRESENT-80 round: key add, S-box, permutation, key update.
// Depends on prs_pkg.
`default_nettype none

module prs_round
  import prs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [RND_W-1:0] rnd,
  input  wire logic             in_valid,
  input  wire prs_stage_t       in_stage,
  output logic                  out_valid,
  output prs_stage_t            out_stage
);

  logic [KEY_W-1:0] key_rot;
  prs_stage_t       stage_next;

  always_comb begin
    stage_next.state = perm_layer(sub_layer(in_stage.state ^ in_stage.key[KEY_W-1 -: BLK_W]));
    key_rot = {in_stage.key[18:0], in_stage.key[KEY_W-1:19]};
    key_rot[KEY_W-1 -: 4] = sbox(key_rot[KEY_W-1 -: 4]);
    key_rot[19:15] = key_rot[19:15] ^ 5'(rnd);
    stage_next.key = key_rot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/present80_block_encrypt.sv =====
// PRESENT-80 ECB encryption top: key registers, input stage, round chain, output stage.
// Depends on prs_pkg and prs_round.
//
//  port group   dir  word / fields
//  s_axis_*     in   tdata[63:0] = plaintext
//  m_axis_*     out  tdata[63:0] = ciphertext
//  cfg_*        in   index 0 key_low (64b), index 1 key_high (16b)
//
// One word per cycle while the output is not stalled; the path is registered at the input
// register, one register per round and the output register with the final key add.
// Synchronous reset clears valid bits and sets the key to zero.
// A stalled output word freezes the whole pipeline; s_axis_tready follows.
`default_nettype none

module present80_block_encrypt
  import prs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [BLK_W-1:0] s_axis_tdata,   // [63:0] plaintext
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [BLK_W-1:0]      m_axis_tdata,   // [63:0] ciphertext
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [KLO_W-1:0] cfg_wdata
);

  logic [KLO_W-1:0] key_low;
  logic [KHI_W-1:0] key_high;
  logic             en;
  logic             stage_v [0:ROUNDS];
  prs_stage_t       stage_d [0:ROUNDS];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_LOW:  key_low  <= cfg_wdata;
        CFG_KEY_HIGH: key_high <= cfg_wdata[KHI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v[0] <= 1'b0;
    end else if (en) begin
      stage_v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_d[0].state <= s_axis_tdata;
      stage_d[0].key   <= {key_high, key_low};
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    prs_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .rnd       (RND_W'(r + 1)),
      .in_valid  (stage_v[r]),
      .in_stage  (stage_d[r]),
      .out_valid (stage_v[r+1]),
      .out_stage (stage_d[r+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= stage_v[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= stage_d[ROUNDS].state ^ stage_d[ROUNDS].key[KEY_W-1 -: BLK_W];
    end
  end

endmodule

`default_nettype wire

// ===== test/present80_checker.sv =====
// Checker for present80_block_encrypt: tracks the key writes, predicts each
// ciphertext word when its plaintext is accepted and compares it in order.
// Depends on prs_pkg for widths, round count and register indexes.
module present80_checker
  import prs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [BLK_W-1:0] s_tdata,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [BLK_W-1:0] m_tdata,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [KLO_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] SBOX_TAB [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  logic [KLO_W-1:0] key_lo = '0;
  logic [KHI_W-1:0] key_hi = '0;
  logic [BLK_W-1:0] cipher_q [$];
  logic [BLK_W-1:0] expected;

  initial begin
    mismatches      = 0;
    words_in_flight = 0;
  end

  function automatic logic [BLK_W-1:0] encrypt_block(input logic [BLK_W-1:0] pt,
                                                     input logic [KLO_W-1:0] klo,
                                                     input logic [KHI_W-1:0] khi);
    logic [KEY_W-1:0] k;
    logic [BLK_W-1:0] s;
    logic [BLK_W-1:0] t;
    k = {khi, klo};
    s = pt;
    for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
      s = s ^ k[KEY_W-1:16];
      for (int n = 0; n < BLK_W / 4; n++) begin
        s[4*n +: 4] = SBOX_TAB[s[4*n +: 4]];
      end
      t = '0;
      for (int i = 0; i < BLK_W; i++) begin
        t[(i == 63) ? 63 : (16 * i) % 63] = s[i];
      end
      s = t;
      // rotate left by 61, S-box on the top nibble, round counter into bits 19..15
      k = {k[18:0], k[KEY_W-1:19]};
      k[KEY_W-1 -: 4] = SBOX_TAB[k[KEY_W-1 -: 4]];
      k[19:15] = k[19:15] ^ 5'(rnd);
    end
    return s ^ k[KEY_W-1:16];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_lo = '0;
      key_hi = '0;
      cipher_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_KEY_LOW) begin
          key_lo = cfg_wdata;
        end else if (cfg_addr == CFG_KEY_HIGH) begin
          key_hi = cfg_wdata[KHI_W-1:0];
        end
      end
      if (s_tvalid && s_tready) begin
        cipher_q.push_back(encrypt_block(s_tdata, key_lo, key_hi));
      end
      if (m_tvalid && m_tready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t unexpected ciphertext word: expected none, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          expected = cipher_q.pop_front();
          if (m_tdata !== expected) begin
            $display("%0t ciphertext mismatch: expected %h, actual %h",
                     $time, expected, m_tdata);
            mismatches++;
          end
        end
      end
    end
    words_in_flight = cipher_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the PRESENT-80 encryption testbench: clock, reset, key writes,
// plaintext stimulus with random gaps and output stalls, and the verdict.
// Depends on prs_pkg, present80_block_encrypt and present80_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import prs_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int PHASE_WORDS = 232;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [BLK_W-1:0] s_axis_tdata = '0;   // [63:0] plaintext
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [BLK_W-1:0] m_axis_tdata;        // [63:0] ciphertext
  logic             cfg_we = 1'b0;
  logic             cfg_addr = CFG_KEY_LOW;
  logic [KLO_W-1:0] cfg_wdata = '0;

  int mismatches;
  int in_flight;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;

  present80_block_encrypt dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  present80_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_axis_tvalid),
    .s_tready       (s_axis_tready),
    .s_tdata        (s_axis_tdata),
    .m_tvalid       (m_axis_tvalid),
    .m_tready       (m_axis_tready),
    .m_tdata        (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .words_in_flight(in_flight)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [BLK_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid and hold off until every ciphertext word has come out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic write_key(input logic [KLO_W-1:0] lo, input logic [KLO_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= CFG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [BLK_W-1:0] rand_block();
    logic [BLK_W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'h1 << $urandom_range(63);
      3:       w = ~(64'h1 << $urandom_range(63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key (all zero)
    send_word(64'h0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h1);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h0123_4567_89AB_CDEF);
    send_word(64'h0123_4567_89AB_CDEF);
    send_word(64'hFEDC_BA98_7654_3210);
    drain;

    // all-ones key; high write carries junk above bit 15
    write_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'h5555_5555_5555_5555);
    send_word(64'h0);
    drain;

    write_key(64'h0, 64'hDEAD_BEEF_0123_FFFF);
    send_word(64'h0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0123_4567_89AB_CDEF);
    drain;

    write_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_0000_0000_0000);
    send_word(64'h0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    drain;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 45; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      write_key({$urandom, $urandom}, {$urandom, $urandom});
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 1 && n == PHASE_WORDS / 2) begin
          drain;
        end
        send_word(rand_block());
      end
      drain;
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prs_pkg.sv
rtl/prs_round.sv
rtl/present80_block_encrypt.sv
test/present80_checker.sv
test/tb_top.sv
